// File: sv/pstrm_pkg.sv
// shared types and constants for the phase stack range and texture core
package pstrm_pkg;

   localparam int FP_W = 21;
   localparam int NF_W = 7;
   localparam int TEX_W = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = FP_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_PIXELS   = 3'd0,
      CSR_NUM_FRAMES     = 3'd1,
      CSR_RANGE_ENABLE   = 3'd2,
      CSR_TEXTURE_ENABLE = 3'd3,
      CSR_COLOR_TEXTURE  = 3'd4,
      CSR_MERGE_PREVIOUS = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic first;
      logic last_frame;
      logic last_pix;
      logic merge;
   } pstrm_flags_type;

   typedef struct packed {
      logic range_enable;
      logic texture_enable;
      logic color_texture;
   } pstrm_mode_type;

endpackage

// File: sv/pstrm_accum.sv
// per-pixel max, min and channel sum accumulation over the frames of a batch
module pstrm_accum #(
   parameter int DEPTH = 1048576,
   parameter int ADDR_W = 20,
   parameter int PIXEL_BITS = 12,
   parameter int SUM_W = 18
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [ADDR_W-1:0]            in_addr,
   input  logic [PIXEL_BITS-1:0]        in_gray,
   input  logic [2:0][PIXEL_BITS-1:0]   in_ch,
   input  pstrm_pkg::pstrm_flags_type   in_flags,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [ADDR_W-1:0]            out_addr,
   output pstrm_pkg::pstrm_flags_type   out_flags,
   output logic [PIXEL_BITS-1:0]        out_max,
   output logic [PIXEL_BITS-1:0]        out_min,
   output logic [2:0][SUM_W-1:0]        out_sum
);
   import pstrm_pkg::*;

   localparam int ENT_W = 2 * PIXEL_BITS + 3 * SUM_W;

   logic [ENT_W-1:0] mem [DEPTH];

   logic                       s1_valid_ff;
   logic [ADDR_W-1:0]          s1_addr_ff;
   logic [PIXEL_BITS-1:0]      s1_gray_ff;
   logic [2:0][PIXEL_BITS-1:0] s1_ch_ff;
   pstrm_flags_type            s1_flags_ff;
   logic [ENT_W-1:0]           rd_ff;
   logic                       byp_ff;
   logic [ENT_W-1:0]           byp_data_ff;

   logic [ENT_W-1:0]      old_ent;
   logic [ENT_W-1:0]      new_ent;
   logic [PIXEL_BITS-1:0] old_max;
   logic [PIXEL_BITS-1:0] old_min;
   logic [PIXEL_BITS-1:0] new_max;
   logic [PIXEL_BITS-1:0] new_min;
   logic [2:0][SUM_W-1:0] old_sum;
   logic [2:0][SUM_W-1:0] new_sum;
   logic                  s1_go;
   logic                  load;

   assign s1_go = !s1_flags_ff.last_frame || out_ready;
   assign in_ready = !s1_valid_ff || s1_go;
   assign load = in_valid && in_ready;

   always_comb begin
      old_ent = byp_ff ? byp_data_ff : rd_ff;
      old_max = old_ent[ENT_W-1 -: PIXEL_BITS];
      old_min = old_ent[ENT_W-PIXEL_BITS-1 -: PIXEL_BITS];
      old_sum = old_ent[3*SUM_W-1:0];
      if (s1_flags_ff.first) begin
         new_max = s1_gray_ff;
         new_min = s1_gray_ff;
         for (int c = 0; c < 3; c++) begin
            new_sum[c] = SUM_W'(s1_ch_ff[c]);
         end
      end else begin
         new_max = (s1_gray_ff > old_max) ? s1_gray_ff : old_max;
         new_min = (s1_gray_ff < old_min) ? s1_gray_ff : old_min;
         for (int c = 0; c < 3; c++) begin
            new_sum[c] = old_sum[c] + SUM_W'(s1_ch_ff[c]);
         end
      end
      new_ent = {new_max, new_min, new_sum};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_ready) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_addr_ff  <= in_addr;
         s1_gray_ff  <= in_gray;
         s1_ch_ff    <= in_ch;
         s1_flags_ff <= in_flags;
         rd_ff       <= mem[in_addr];
         byp_ff      <= s1_valid_ff && (s1_addr_ff == in_addr);
         byp_data_ff <= new_ent;
      end
      if (s1_valid_ff && s1_go) begin
         mem[s1_addr_ff] <= new_ent;
      end
   end

   assign out_valid = s1_valid_ff && s1_flags_ff.last_frame;
   assign out_addr  = s1_addr_ff;
   assign out_flags = s1_flags_ff;
   assign out_max   = new_max;
   assign out_min   = new_min;
   assign out_sum   = new_sum;

endmodule

// File: sv/pstrm_div.sv
// range and pipelined texture division by the frame count through a reciprocal table
module pstrm_div #(
   parameter int ADDR_W = 20,
   parameter int PIXEL_BITS = 12,
   parameter int SUM_W = 18,
   parameter int MAX_FRAMES = 64,
   parameter int TEXTURE_FRAC_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [$clog2(MAX_FRAMES+1)-1:0]        nf,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [ADDR_W-1:0]                      in_addr,
   input  pstrm_pkg::pstrm_flags_type             in_flags,
   input  logic [PIXEL_BITS-1:0]                  in_max,
   input  logic [PIXEL_BITS-1:0]                  in_min,
   input  logic [2:0][SUM_W-1:0]                  in_sum,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [ADDR_W-1:0]                      out_addr,
   output pstrm_pkg::pstrm_flags_type             out_flags,
   output logic [PIXEL_BITS-1:0]                  out_range,
   output logic [2:0][pstrm_pkg::TEX_W-1:0]       out_tex
);
   import pstrm_pkg::*;

   localparam int DW = $clog2(MAX_FRAMES + 1);
   localparam int XW = SUM_W + TEXTURE_FRAC_BITS + 1;
   localparam int PW = 2 * XW;
   localparam int QDW = XW + DW;

   logic [XW-1:0] recip_tab [MAX_FRAMES+1];

   assign recip_tab[0] = '0;
   assign recip_tab[1] = '0;
   for (genvar g = 2; g <= MAX_FRAMES; g++) begin : g_recip
      localparam logic [XW-1:0] RECIP = XW'((64'd1 << XW) / 64'(g));
      assign recip_tab[g] = RECIP;
   end

   // stage 2: operands
   logic                  v2_ff;
   logic [ADDR_W-1:0]     a2_ff;
   pstrm_flags_type       f2_ff;
   logic [PIXEL_BITS-1:0] max2_ff;
   logic [PIXEL_BITS-1:0] min2_ff;
   logic [2:0][SUM_W-1:0] sum2_ff;
   // stage 3: reciprocal products
   logic                  v3_ff;
   logic [ADDR_W-1:0]     a3_ff;
   pstrm_flags_type       f3_ff;
   logic [PIXEL_BITS-1:0] r3_ff;
   logic [2:0][XW-1:0]    x3_ff;
   logic [2:0][PW-1:0]    p3_ff;
   // stage 4: quotient estimate and back product
   logic                  v4_ff;
   logic [ADDR_W-1:0]     a4_ff;
   pstrm_flags_type       f4_ff;
   logic [PIXEL_BITS-1:0] r4_ff;
   logic [2:0][XW-1:0]    x4_ff;
   logic [2:0][XW-1:0]    q4_ff;
   logic [2:0][QDW-1:0]   qd4_ff;

   logic rdy2;
   logic rdy3;
   logic rdy4;

   logic [XW-1:0]         m2;
   logic [2:0][XW-1:0]    x2;
   logic [2:0][PW-1:0]    p2;
   logic [2:0][XW-1:0]    q3;
   logic [2:0][QDW-1:0]   qd3;
   logic [2:0][XW-1:0]    rem4;
   logic [2:0][XW-1:0]    q4;

   assign rdy4 = !v4_ff || out_ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign in_ready = rdy2;

   always_comb begin
      m2 = recip_tab[nf];
      for (int c = 0; c < 3; c++) begin
         x2[c] = XW'(sum2_ff[c]) << (TEXTURE_FRAC_BITS + 1);
         p2[c] = PW'(x2[c]) * PW'(m2);
         q3[c] = p3_ff[c][PW-1:XW];
         qd3[c] = QDW'(q3[c]) * QDW'(nf);
         rem4[c] = x4_ff[c] - qd4_ff[c][XW-1:0];
         if (nf == DW'(1)) begin
            q4[c] = x4_ff[c];
         end else if (rem4[c] >= XW'(nf)) begin
            q4[c] = q4_ff[c] + XW'(1);
         end else begin
            q4[c] = q4_ff[c];
         end
         if ((XW > TEX_W) && ((q4[c] >> TEX_W) != '0)) begin
            out_tex[c] = '1;
         end else begin
            out_tex[c] = TEX_W'(q4[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy2) v2_ff <= in_valid;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && in_valid) begin
         a2_ff   <= in_addr;
         f2_ff   <= in_flags;
         max2_ff <= in_max;
         min2_ff <= in_min;
         sum2_ff <= in_sum;
      end
      if (rdy3 && v2_ff) begin
         a3_ff <= a2_ff;
         f3_ff <= f2_ff;
         r3_ff <= max2_ff - min2_ff;
         x3_ff <= x2;
         p3_ff <= p2;
      end
      if (rdy4 && v3_ff) begin
         a4_ff  <= a3_ff;
         f4_ff  <= f3_ff;
         r4_ff  <= r3_ff;
         x4_ff  <= x3_ff;
         q4_ff  <= q3;
         qd4_ff <= qd3;
      end
   end

   assign out_valid = v4_ff;
   assign out_addr  = a4_ff;
   assign out_flags = f4_ff;
   assign out_range = r4_ff;

endmodule

// File: sv/pstrm_merge.sv
// merge with stored results of earlier batches and result output register
module pstrm_merge #(
   parameter int DEPTH = 1048576,
   parameter int ADDR_W = 20,
   parameter int PIXEL_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pstrm_pkg::pstrm_mode_type          mode,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [ADDR_W-1:0]                  in_addr,
   input  pstrm_pkg::pstrm_flags_type         in_flags,
   input  logic [PIXEL_BITS-1:0]              in_range,
   input  logic [2:0][pstrm_pkg::TEX_W-1:0]   in_tex,
   output logic                               out_valid,
   input  logic                               out_stall,
   output logic [PIXEL_BITS-1:0]              out_range,
   output logic [2:0][pstrm_pkg::TEX_W-1:0]   out_tex,
   output logic                               out_last_pixel
);
   import pstrm_pkg::*;

   localparam int ENT_W = PIXEL_BITS + 3 * TEX_W;

   logic [ENT_W-1:0] mem [DEPTH];

   logic                  v5_ff;
   logic [ADDR_W-1:0]     a5_ff;
   pstrm_flags_type       f5_ff;
   logic [PIXEL_BITS-1:0] r5_ff;
   logic [2:0][TEX_W-1:0] t5_ff;
   logic [ENT_W-1:0]      rd_ff;
   logic                  byp_ff;
   logic [ENT_W-1:0]      byp_data_ff;

   logic                  v6_ff;
   logic [PIXEL_BITS-1:0] r6_ff;
   logic [2:0][TEX_W-1:0] t6_ff;
   logic                  lp6_ff;

   logic                  rdy6;
   logic                  load;
   logic [ENT_W-1:0]      old_ent;
   logic [PIXEL_BITS-1:0] old_range;
   logic [2:0][TEX_W-1:0] old_tex;
   logic [PIXEL_BITS-1:0] new_range;
   logic [2:0][TEX_W-1:0] new_tex;
   logic [TEX_W:0]        tex_sum;
   logic [2:0]            ch_en;

   assign rdy6 = !v6_ff || !out_stall;
   assign in_ready = !v5_ff || rdy6;
   assign load = in_valid && in_ready;

   always_comb begin
      old_ent = byp_ff ? byp_data_ff : rd_ff;
      old_range = old_ent[ENT_W-1 -: PIXEL_BITS];
      old_tex = old_ent[3*TEX_W-1:0];
      ch_en[0] = mode.texture_enable;
      ch_en[1] = mode.texture_enable && mode.color_texture;
      ch_en[2] = mode.texture_enable && mode.color_texture;
      if (!mode.range_enable) begin
         new_range = '0;
      end else if (f5_ff.merge && (old_range < r5_ff)) begin
         new_range = old_range;
      end else begin
         new_range = r5_ff;
      end
      tex_sum = '0;
      for (int c = 0; c < 3; c++) begin
         tex_sum = {1'b0, t5_ff[c]} + {1'b0, old_tex[c]};
         if (!ch_en[c]) begin
            new_tex[c] = '0;
         end else if (!f5_ff.merge) begin
            new_tex[c] = t5_ff[c];
         end else if (tex_sum[TEX_W]) begin
            new_tex[c] = '1;
         end else begin
            new_tex[c] = tex_sum[TEX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (in_ready) v5_ff <= in_valid;
         if (rdy6) v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         a5_ff       <= in_addr;
         f5_ff       <= in_flags;
         r5_ff       <= in_range;
         t5_ff       <= in_tex;
         rd_ff       <= mem[in_addr];
         byp_ff      <= v5_ff && (a5_ff == in_addr);
         byp_data_ff <= {new_range, new_tex};
      end
      if (v5_ff && rdy6) begin
         mem[a5_ff] <= {new_range, new_tex};
         r6_ff      <= new_range;
         t6_ff      <= new_tex;
         lp6_ff     <= f5_ff.last_pix;
      end
   end

   assign out_valid      = v6_ff;
   assign out_range      = r6_ff;
   assign out_tex        = t6_ff;
   assign out_last_pixel = lp6_ff;

endmodule

// File: sv/phase_stack_range_texture_merge_core.sv
// top level: registers, pixel and frame counters, pipeline of accumulate, divide, merge
//
// channel  | ports                         | transfer when
// ---------+-------------------------------+---------------------------
// request  | req_valid/stall, gray..red    | req_valid and not req_stall
// response | rsp_valid/stall, range, tex   | rsp_valid and not rsp_stall
// csr      | csr_valid/ready, index, data  | csr_valid and csr_ready
//
// one pixel per cycle while req_stall is low; a result leaves after its pixel passes every stage
// path: the store read, operand register, two multiplier stages, merge store read, output register
// only pixels of a batch's last frame give a response
// reset clears counters, valid bits and csr registers; the stores are not cleared
// a response stall fills pipeline bubbles first, then stalls the request side
module phase_stack_range_texture_merge_core #(
   parameter int MAX_PIXELS = 1048576,
   parameter int PIXEL_BITS = 12,
   parameter int MAX_FRAMES = 64,
   parameter int TEXTURE_FRAC_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [PIXEL_BITS-1:0]             req_gray,
   input  logic [PIXEL_BITS-1:0]             req_blue,
   input  logic [PIXEL_BITS-1:0]             req_green,
   input  logic [PIXEL_BITS-1:0]             req_red,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [PIXEL_BITS-1:0]             rsp_range,
   output logic [pstrm_pkg::TEX_W-1:0]       rsp_texture_ch0,
   output logic [pstrm_pkg::TEX_W-1:0]       rsp_texture_ch1,
   output logic [pstrm_pkg::TEX_W-1:0]       rsp_texture_ch2,
   output logic                              rsp_last_pixel,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pstrm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pstrm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import pstrm_pkg::*;

   localparam int AW = $clog2(MAX_PIXELS);
   localparam int FW = $clog2(MAX_FRAMES);
   localparam int DW = $clog2(MAX_FRAMES + 1);
   localparam int SUM_W = PIXEL_BITS + FW;

   logic [FP_W-1:0] frame_pixels_ff;
   logic [NF_W-1:0] num_frames_ff;
   pstrm_mode_type  mode_ff;
   logic            merge_previous_ff;

   logic [AW-1:0]   pix_pos_ff;
   logic [AW-1:0]   pix_pos_in;
   logic [FW-1:0]   frame_pos_ff;
   logic [FW-1:0]   frame_pos_in;
   logic            have_prev_ff;
   logic            have_prev_in;

   logic [31:0]     fp_clamp;
   logic [DW-1:0]   nf_clamp;
   logic            accept;
   logic            acc_ready;
   pstrm_flags_type flags;
   logic [2:0][PIXEL_BITS-1:0] ch;

   logic                       a_valid;
   logic                       a_ready;
   logic [AW-1:0]              a_addr;
   pstrm_flags_type            a_flags;
   logic [PIXEL_BITS-1:0]      a_max;
   logic [PIXEL_BITS-1:0]      a_min;
   logic [2:0][SUM_W-1:0]      a_sum;

   logic                       d_valid;
   logic                       d_ready;
   logic [AW-1:0]              d_addr;
   pstrm_flags_type            d_flags;
   logic [PIXEL_BITS-1:0]      d_range;
   logic [2:0][TEX_W-1:0]      d_tex;
   logic [2:0][TEX_W-1:0]      m_tex;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pixels_ff        <= FP_W'(1048576);
         num_frames_ff          <= NF_W'(4);
         mode_ff.range_enable   <= 1'b1;
         mode_ff.texture_enable <= 1'b1;
         mode_ff.color_texture  <= 1'b0;
         merge_previous_ff      <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_PIXELS:   frame_pixels_ff        <= csr_data;
            CSR_NUM_FRAMES:     num_frames_ff          <= csr_data[NF_W-1:0];
            CSR_RANGE_ENABLE:   mode_ff.range_enable   <= csr_data[0];
            CSR_TEXTURE_ENABLE: mode_ff.texture_enable <= csr_data[0];
            CSR_COLOR_TEXTURE:  mode_ff.color_texture  <= csr_data[0];
            CSR_MERGE_PREVIOUS: merge_previous_ff      <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (frame_pixels_ff == '0) begin
         fp_clamp = 32'd1;
      end else if (32'(frame_pixels_ff) > 32'(MAX_PIXELS)) begin
         fp_clamp = 32'(MAX_PIXELS);
      end else begin
         fp_clamp = 32'(frame_pixels_ff);
      end
      if (num_frames_ff == '0) begin
         nf_clamp = DW'(1);
      end else if (32'(num_frames_ff) > 32'(MAX_FRAMES)) begin
         nf_clamp = DW'(MAX_FRAMES);
      end else begin
         nf_clamp = DW'(num_frames_ff);
      end
      flags.first      = (frame_pos_ff == '0);
      flags.last_frame = (32'(frame_pos_ff) + 32'd1) >= 32'(nf_clamp);
      flags.last_pix   = (32'(pix_pos_ff) + 32'd1) >= fp_clamp;
      flags.merge      = merge_previous_ff && have_prev_ff;
      if (mode_ff.color_texture) begin
         ch[0] = req_blue;
         ch[1] = req_green;
         ch[2] = req_red;
      end else begin
         ch[0] = req_gray;
         ch[1] = '0;
         ch[2] = '0;
      end
   end

   assign req_stall = !acc_ready;
   assign accept = req_valid && acc_ready;

   always_comb begin
      pix_pos_in   = pix_pos_ff;
      frame_pos_in = frame_pos_ff;
      have_prev_in = have_prev_ff;
      if (accept) begin
         if (flags.last_pix) begin
            pix_pos_in = '0;
            if (flags.last_frame) begin
               frame_pos_in = '0;
               have_prev_in = 1'b1;
            end else begin
               frame_pos_in = frame_pos_ff + FW'(1);
            end
         end else begin
            pix_pos_in = pix_pos_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_pos_ff   <= '0;
         frame_pos_ff <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         pix_pos_ff   <= pix_pos_in;
         frame_pos_ff <= frame_pos_in;
         have_prev_ff <= have_prev_in;
      end
   end

   pstrm_accum #(
      .DEPTH      (MAX_PIXELS),
      .ADDR_W     (AW),
      .PIXEL_BITS (PIXEL_BITS),
      .SUM_W      (SUM_W)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (acc_ready),
      .in_addr   (pix_pos_ff),
      .in_gray   (req_gray),
      .in_ch     (ch),
      .in_flags  (flags),
      .out_valid (a_valid),
      .out_ready (a_ready),
      .out_addr  (a_addr),
      .out_flags (a_flags),
      .out_max   (a_max),
      .out_min   (a_min),
      .out_sum   (a_sum)
   );

   pstrm_div #(
      .ADDR_W            (AW),
      .PIXEL_BITS        (PIXEL_BITS),
      .SUM_W             (SUM_W),
      .MAX_FRAMES        (MAX_FRAMES),
      .TEXTURE_FRAC_BITS (TEXTURE_FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .nf        (nf_clamp),
      .in_valid  (a_valid),
      .in_ready  (a_ready),
      .in_addr   (a_addr),
      .in_flags  (a_flags),
      .in_max    (a_max),
      .in_min    (a_min),
      .in_sum    (a_sum),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_addr  (d_addr),
      .out_flags (d_flags),
      .out_range (d_range),
      .out_tex   (d_tex)
   );

   pstrm_merge #(
      .DEPTH      (MAX_PIXELS),
      .ADDR_W     (AW),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_merge (
      .clock          (clock),
      .reset          (reset),
      .mode           (mode_ff),
      .in_valid       (d_valid),
      .in_ready       (d_ready),
      .in_addr        (d_addr),
      .in_flags       (d_flags),
      .in_range       (d_range),
      .in_tex         (d_tex),
      .out_valid      (rsp_valid),
      .out_stall      (rsp_stall),
      .out_range      (rsp_range),
      .out_tex        (m_tex),
      .out_last_pixel (rsp_last_pixel)
   );

   assign rsp_texture_ch0 = m_tex[0];
   assign rsp_texture_ch1 = m_tex[1];
   assign rsp_texture_ch2 = m_tex[2];

endmodule

// File: sim/tb_phase_stack_range_texture_merge_core.sv
// testbench for the phase stack range and texture merge core with a scoreboard class
`timescale 1ns / 1ps

module tb_phase_stack_range_texture_merge_core;
   import pstrm_pkg::*;

   localparam int PIX_MAX = 1048576;
   localparam int FRM_MAX = 64;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 16;

   typedef struct {
      bit [11:0] range;
      bit [31:0] tex0;
      bit [31:0] tex1;
      bit [31:0] tex2;
      bit        last_pixel;
   } texture_result_type;

   class range_texture_scoreboard;
      bit [20:0] frame_pixels = 21'd1048576;
      bit [6:0]  num_frames = 7'd4;
      bit        range_enable = 1'b1;
      bit        texture_enable = 1'b1;
      bit        color_texture = 1'b0;
      bit        merge_previous = 1'b0;
      bit [11:0] pix_max [int];
      bit [11:0] pix_min [int];
      bit [31:0] chan_sum [3][int];
      bit [11:0] merged_range [int];
      bit [31:0] merged_tex [3][int];
      int unsigned pixel_pos = 0;
      int unsigned frame_pos = 0;
      bit          have_previous = 0;
      int unsigned merged_pixels = 0;
      texture_result_type pending [$];
      int errors = 0;

      function int unsigned eff_pixels();
         if (frame_pixels < 1) return 1;
         if (frame_pixels > PIX_MAX) return PIX_MAX;
         return frame_pixels;
      endfunction

      function int unsigned eff_frames();
         if (num_frames < 1) return 1;
         if (num_frames > FRM_MAX) return FRM_MAX;
         return num_frames;
      endfunction

      function void write_reg(csr_index_type idx, bit [20:0] value);
         case (idx)
            CSR_FRAME_PIXELS:   frame_pixels = value;
            CSR_NUM_FRAMES:     num_frames = value[6:0];
            CSR_RANGE_ENABLE:   range_enable = value[0];
            CSR_TEXTURE_ENABLE: texture_enable = value[0];
            CSR_COLOR_TEXTURE:  color_texture = value[0];
            CSR_MERGE_PREVIOUS: merge_previous = value[0];
            default: ;
         endcase
      endfunction

      function void note_pixel(bit [11:0] g, bit [11:0] b, bit [11:0] gr, bit [11:0] r);
         int unsigned fp, nf, p;
         bit first, last_frame, last_pix, merge;
         bit [11:0] ch [3];
         bit [11:0] rng;
         longint unsigned t [3];
         texture_result_type res;
         fp = eff_pixels();
         nf = eff_frames();
         p = pixel_pos % PIX_MAX;
         first = (frame_pos == 0);
         last_frame = (frame_pos + 1 >= nf);
         last_pix = (p + 1 >= fp);
         if (color_texture) begin
            ch[0] = b; ch[1] = gr; ch[2] = r;
         end else begin
            ch[0] = g; ch[1] = 0; ch[2] = 0;
         end
         if (first) begin
            pix_max[p] = g;
            pix_min[p] = g;
            for (int c = 0; c < 3; c++) chan_sum[c][p] = ch[c];
         end else begin
            if (g > pix_max[p]) pix_max[p] = g;
            if (g < pix_min[p]) pix_min[p] = g;
            for (int c = 0; c < 3; c++) chan_sum[c][p] += ch[c];
         end
         if (last_frame) begin
            merge = merge_previous && have_previous;
            rng = 0;
            if (range_enable) begin
               rng = pix_max[p] - pix_min[p];
               if (merge && merged_range[p] < rng) rng = merged_range[p];
            end
            for (int c = 0; c < 3; c++) begin
               t[c] = 0;
               if (texture_enable && (c == 0 || color_texture)) begin
                  t[c] = (longint'(chan_sum[c][p]) << 9) / nf;
                  if (t[c] > 64'hFFFF_FFFF) t[c] = 64'hFFFF_FFFF;
                  if (merge) begin
                     t[c] += merged_tex[c][p];
                     if (t[c] > 64'hFFFF_FFFF) t[c] = 64'hFFFF_FFFF;
                  end
               end
               merged_tex[c][p] = t[c][31:0];
            end
            merged_range[p] = rng;
            res.range = rng;
            res.tex0 = t[0][31:0];
            res.tex1 = t[1][31:0];
            res.tex2 = t[2][31:0];
            res.last_pixel = last_pix;
            pending.push_back(res);
         end
         if (last_pix) begin
            pixel_pos = 0;
            if (last_frame) begin
               frame_pos = 0;
               have_previous = 1;
               if (fp > merged_pixels) merged_pixels = fp;
            end else begin
               frame_pos++;
            end
         end else begin
            pixel_pos = p + 1;
         end
      endfunction

      task report(string what, longint unsigned got, longint unsigned want);
         $display("mismatch %s: got %0h expected %0h", what, got, want);
         errors++;
      endtask

      task check_result(bit [11:0] rng, bit [31:0] t0, bit [31:0] t1, bit [31:0] t2,
                        bit lp);
         texture_result_type w;
         if (pending.size() == 0) begin
            report("unexpected result", rng, 0);
            return;
         end
         w = pending.pop_front();
         if (rng != w.range) report("range", rng, w.range);
         if (t0 != w.tex0) report("texture_ch0", t0, w.tex0);
         if (t1 != w.tex1) report("texture_ch1", t1, w.tex1);
         if (t2 != w.tex2) report("texture_ch2", t2, w.tex2);
         if (lp != w.last_pixel) report("last_pixel", lp, w.last_pixel);
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [11:0] req_gray = 0, req_blue = 0, req_green = 0, req_red = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [11:0] rsp_range;
   logic [31:0] rsp_texture_ch0, rsp_texture_ch1, rsp_texture_ch2;
   logic        rsp_last_pixel;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = 0;
   logic [CSR_DATA_W-1:0] csr_data = 0;

   range_texture_scoreboard board = new();
   int unsigned cycles = 0;
   int unsigned pixels_sent = 0;

   phase_stack_range_texture_merge_core dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // no idling in this window
   function bit busy_free();
      return cycles >= 600 && cycles < 1400;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_stall <= busy_free() ? 1'b0 : ($urandom_range(99) < 17);
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_pixel(req_gray, req_blue, req_green, req_red);
         if (rsp_valid && !rsp_stall)
            board.check_result(rsp_range, rsp_texture_ch0, rsp_texture_ch1,
                               rsp_texture_ch2, rsp_last_pixel);
      end
   end

   task write_csr(csr_index_type idx, bit [20:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task wait_idle();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function bit [11:0] pick_value(bit extremes);
      if (extremes || $urandom_range(7) == 0) return $urandom_range(1) ? 12'hFFF : 12'h000;
      return 12'($urandom_range(4095));
   endfunction

   task send_pixel(bit extremes);
      while (!busy_free() && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_gray <= pick_value(extremes);
      req_blue <= pick_value(extremes);
      req_green <= pick_value(extremes);
      req_red <= pick_value(extremes);
      do @(posedge clock); while (req_stall);
      pixels_sent++;
   endtask

   task run_phase(bit [20:0] fp, bit [6:0] nf, bit re, bit te, bit ct, bit mg,
                  int batches, bit extremes);
      int unsigned fp_eff, nf_eff;
      wait_idle();
      write_csr(CSR_FRAME_PIXELS, fp);
      write_csr(CSR_NUM_FRAMES, 21'(nf));
      write_csr(CSR_RANGE_ENABLE, 21'(re));
      write_csr(CSR_TEXTURE_ENABLE, 21'(te));
      write_csr(CSR_COLOR_TEXTURE, 21'(ct));
      fp_eff = board.eff_pixels();
      nf_eff = board.eff_frames();
      // merging into pixels never stored before is not allowed
      if (board.have_previous && fp_eff > board.merged_pixels) mg = 0;
      write_csr(CSR_MERGE_PREVIOUS, 21'(mg));
      for (int k = 0; k < batches * fp_eff * nf_eff; k++) send_pixel(extremes);
      req_valid <= 1'b0;
   endtask

   initial begin
      bit [20:0] fp;
      bit [6:0]  nf;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // out of range values, replaced before any pixel
      write_csr(CSR_FRAME_PIXELS, 21'h1FFFFF);
      write_csr(CSR_NUM_FRAMES, 21'd0);
      run_phase(21'd1, 7'd1, 1, 1, 0, 0, 2, 1);
      run_phase(21'd0, 7'd0, 1, 1, 1, 1, 2, 1);
      run_phase(21'd2, 7'd3, 1, 1, 1, 1, 1, 1);
      run_phase(21'd2, 7'd2, 0, 0, 0, 1, 1, 1);
      run_phase(21'd1, 7'd100, 1, 1, 1, 1, 1, 0);
      run_phase(21'd1, 7'd64, 1, 1, 0, 1, 1, 0);
      while (pixels_sent < 1150) begin
         fp = ($urandom_range(9) == 0) ? 21'($urandom_range(0, 1)) :
                                         21'($urandom_range(1, 12));
         case ($urandom_range(9))
            0: nf = 7'd1;
            1: nf = $urandom_range(0, 1) ? 7'd0 : 7'd127;
            default: nf = 7'($urandom_range(2, 8));
         endcase
         // keep long batches short in pixels
         if (nf == 7'd127) fp = 21'd1;
         run_phase(fp, nf, $urandom_range(5) != 0, $urandom_range(5) != 0,
                   $urandom_range(1) != 0, $urandom_range(2) != 0,
                   int'($urandom_range(1, 3)), 0);
      end
      wait_idle();
      if (board.pending.size() != 0) board.report("missing results", 0, board.pending.size());
      if (board.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
sv/pstrm_pkg.sv
sv/pstrm_accum.sv
sv/pstrm_div.sv
sv/pstrm_merge.sv
sv/phase_stack_range_texture_merge_core.sv
sim/tb_phase_stack_range_texture_merge_core.sv
